>>> sv/oli_pkg.sv
// Shared types and codes for the ordered list block.
package oli_pkg;

    // Input beat action codes
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_APPEND  = 3'd1;
    localparam logic [2:0] ACT_INSERT  = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_DISPLAY = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Most result beats one display emits
    localparam int MAX_RESULTS = 16;

    // Cell operation codes
    localparam logic [2:0] COP_HOLD   = 3'd0;
    localparam logic [2:0] COP_CLEAR  = 3'd1;
    localparam logic [2:0] COP_APPEND = 3'd2;
    localparam logic [2:0] COP_INSERT = 3'd3;
    localparam logic [2:0] COP_DELETE = 3'd4;
    localparam logic [2:0] COP_ROTATE = 3'd5;

    // Control broadcast to every cell
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
        logic signed [31:0] wrap_value;
    } cell_ctrl_t;

endpackage

>>> sv/oli_cell.sv
// One list cell: holds an entry and shifts it to or from its neighbors.
module oli_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  oli_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0] left_value,
    input  logic               left_valid,
    input  logic signed [31:0] right_value,
    input  logic               right_valid,
    input  logic               seen_in,
    output logic signed [31:0] value,
    output logic               valid,
    output logic               seen_out
);
    import oli_pkg::*;

    logic signed [31:0] value_reg, value_next;
    logic               valid_reg, valid_next;
    logic               match;

    // Compare against the key; pass "match seen so far" to the right
    assign match    = valid_reg && (value_reg == ctrl.key);
    assign seen_out = seen_in || match;

    // Select the next entry for this cell
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            COP_CLEAR: begin
                valid_next = 1'b0;
            end
            COP_APPEND: begin
                if (left_valid && !valid_reg) begin
                    value_next = ctrl.new_value;
                end
                valid_next = left_valid;
            end
            COP_INSERT: begin
                if (seen_in) begin
                    value_next = left_value;
                end else if (match) begin
                    value_next = ctrl.new_value;
                end
                valid_next = left_valid;
            end
            COP_DELETE: begin
                if (seen_in || match) begin
                    value_next = right_value;
                end
                valid_next = right_valid;
            end
            COP_ROTATE: begin
                value_next = right_valid ? right_value : ctrl.wrap_value;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

>>> sv/ordered_list_insert_delete.sv
// Top level of the ordered list: a row of cells, edit decode and display sequencer.
//
//  channel | dir | beat contents
//  s_      | in  | tuser[2:0] action; tdata[31:0] key, [63:32] new_value
//  m_      | out | tuser[1:0] status; tdata[31:0] entry_value; tlast last
//
// For clear, append, insert and delete, every cell compares the key
// at once and the row shifts in a single step; the result lands in the output
// register. Display turns the ring of valid cells a full turn, one place per cycle
// unless the m_ side stalls, while cell 0 feeds the output; only the first
// MAX_RESULTS entries are sent. Reset clears the valid bits and the count at
// once, no sweep. A stalled m_ side holds the display and blocks new s_ beats.
module ordered_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] new_value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] entry_value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import oli_pkg::*;

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int NDISP_MX = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    cell_ctrl_t         ctrl;
    logic signed [31:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY:0]   seen;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          mv_reg, mv_next;
    logic [1:0]    mstat_reg, mstat_next;
    logic [31:0]   mval_reg, mval_next;
    logic          mlast_reg, mlast_next;

    logic          accept, out_free, found, is_empty, is_full, step, emit;
    logic [CW-1:0] n_disp;
    logic [2:0]    action;

    // Row of cells, left to right in list order
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0] lv, rv;
        logic               lok, rok;
        if (i == 0) begin : g_head
            assign lv  = '0;
            assign lok = 1'b1;
        end else begin : g_mid_l
            assign lv  = cell_value[i-1];
            assign lok = cell_valid[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign rv  = '0;
            assign rok = 1'b0;
        end else begin : g_mid_r
            assign rv  = cell_value[i+1];
            assign rok = cell_valid[i+1];
        end
        oli_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_valid  (lok),
            .right_value (rv),
            .right_valid (rok),
            .seen_in     (seen[i]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .seen_out    (seen[i+1])
        );
    end

    assign found    = seen[CAPACITY];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign n_disp   = (count_reg > CW'(NDISP_MX)) ? CW'(NDISP_MX) : count_reg;
    assign action   = s_tuser;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = !busy_reg && out_free;
    assign accept   = s_tvalid && s_tready;
    assign emit     = busy_reg && (idx_reg < n_disp);
    assign step     = busy_reg && (!emit || out_free);

    // Decode the beat, drive the cells, load the output register
    always_comb begin
        ctrl.op         = COP_HOLD;
        ctrl.key        = s_tdata[31:0];
        ctrl.new_value  = s_tdata[63:32];
        ctrl.wrap_value = cell_value[0];
        count_next = count_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        mv_next    = mv_reg && !m_tready;
        mstat_next = mstat_reg;
        mval_next  = mval_reg;
        mlast_next = mlast_reg;
        if (accept) begin
            mv_next    = 1'b1;
            mstat_next = ST_OK;
            mval_next  = '0;
            mlast_next = 1'b1;
            case (action)
                ACT_CLEAR: begin
                    ctrl.op    = COP_CLEAR;
                    count_next = '0;
                end
                ACT_APPEND: begin
                    if (is_full) begin
                        mstat_next = ST_FULL;
                    end else begin
                        ctrl.op    = COP_APPEND;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_INSERT: begin
                    if (is_empty) begin
                        mstat_next = ST_EMPTY;
                    end else if (!found) begin
                        mstat_next = ST_NOT_FOUND;
                    end else if (is_full) begin
                        mstat_next = ST_FULL;
                    end else begin
                        ctrl.op    = COP_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_DELETE: begin
                    if (is_empty) begin
                        mstat_next = ST_EMPTY;
                    end else if (!found) begin
                        mstat_next = ST_NOT_FOUND;
                    end else begin
                        ctrl.op    = COP_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_DISPLAY: begin
                    if (is_empty) begin
                        mstat_next = ST_EMPTY;
                    end else begin
                        // hold off the output; the sequencer sends the entries
                        mv_next   = mv_reg && !m_tready;
                        busy_next = 1'b1;
                        idx_next  = '0;
                    end
                end
                default: begin
                    mstat_next = ST_OK;
                end
            endcase
        end else if (step) begin
            // Rotate the ring one place; send cell 0 while under the limit
            ctrl.op = COP_ROTATE;
            if (emit) begin
                mv_next    = 1'b1;
                mstat_next = ST_OK;
                mval_next  = cell_value[0];
                mlast_next = (idx_reg == n_disp - CW'(1));
            end
            idx_next = idx_reg + CW'(1);
            if (idx_reg == count_reg - CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            mv_reg    <= mv_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        mstat_reg <= mstat_next;
        mval_reg  <= mval_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = mval_reg;
    assign m_tlast  = mlast_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input taken during display");

    a_rotate_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && $past(busy_reg) && aresetn && $past(aresetn))
            |-> $stable(count_reg))
        else $error("entry count changed during display");
`endif

endmodule

>>> test/ordered_list_insert_delete_test.sv
// Self-checking testbench for the ordered list block: shadow list, stream drivers, beat checker.
module ordered_list_insert_delete_test;
    import oli_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int CLK_PERIOD = 4;
    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_TAIL = 40;
    localparam int HOLD_AT_ITEM = 150;
    localparam int PAUSE_AT_ITEM = 300;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_CYCLES = 600000;

    // Action codes the block ignores
    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

    typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } list_mode_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } list_beat_t;

    // Shadow list plus the queue of result beats still owed by the block
    class list_tracker;
        logic signed [31:0] entries[$];
        list_beat_t awaited[$];
        int errors;
        int beats_seen;
        int displays;
        int refusals;
        int deepest;

        function void push_beat(logic [1:0] st, logic signed [31:0] v, logic l);
            list_beat_t b;
            b.status = st;
            b.value = v;
            b.last = l;
            awaited.push_back(b);
        endfunction

        function int find_first(logic signed [31:0] k);
            foreach (entries[i])
                if (entries[i] == k)
                    return i;
            return -1;
        endfunction

        // Apply one accepted command to the shadow list and queue its beats
        function void note_command(logic [2:0] act, logic signed [31:0] key,
                                   logic signed [31:0] nv);
            int pos;
            int n;
            case (act)
                ACT_CLEAR: begin
                    entries.delete();
                    push_beat(ST_OK, 0, 1'b1);
                end
                ACT_APPEND: begin
                    if (entries.size() >= LIST_CAPACITY) begin
                        refusals++;
                        push_beat(ST_FULL, 0, 1'b1);
                    end else begin
                        entries.push_back(nv);
                        push_beat(ST_OK, 0, 1'b1);
                    end
                end
                ACT_INSERT: begin
                    pos = find_first(key);
                    if (entries.size() == 0) begin
                        push_beat(ST_EMPTY, 0, 1'b1);
                    end else if (pos < 0) begin
                        push_beat(ST_NOT_FOUND, 0, 1'b1);
                    end else if (entries.size() >= LIST_CAPACITY) begin
                        refusals++;
                        push_beat(ST_FULL, 0, 1'b1);
                    end else begin
                        entries.insert(pos, nv);
                        push_beat(ST_OK, 0, 1'b1);
                    end
                end
                ACT_DELETE: begin
                    pos = find_first(key);
                    if (entries.size() == 0) begin
                        push_beat(ST_EMPTY, 0, 1'b1);
                    end else if (pos < 0) begin
                        push_beat(ST_NOT_FOUND, 0, 1'b1);
                    end else begin
                        entries.delete(pos);
                        push_beat(ST_OK, 0, 1'b1);
                    end
                end
                ACT_DISPLAY: begin
                    displays++;
                    if (entries.size() == 0) begin
                        push_beat(ST_EMPTY, 0, 1'b1);
                    end else begin
                        n = (entries.size() > MAX_RESULTS) ? MAX_RESULTS : entries.size();
                        for (int i = 0; i < n; i++)
                            push_beat(ST_OK, entries[i], (i == n - 1));
                    end
                end
                default: push_beat(ST_OK, 0, 1'b1);
            endcase
            if (entries.size() > deepest)
                deepest = entries.size();
        endfunction

        // Compare one accepted result beat with the oldest owed beat
        function void check_beat(logic [1:0] st, logic [31:0] v, logic l);
            list_beat_t want;
            beats_seen++;
            if (awaited.size() == 0) begin
                $error("unexpected result beat: status %0d entry_value %0d last %0b",
                       st, $signed(v), l);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status) begin
                $error("status expected %0d got %0d", want.status, st);
                errors++;
            end
            if (v !== want.value) begin
                $error("entry_value expected %0d got %0d", want.value, $signed(v));
                errors++;
            end
            if (l !== want.last) begin
                $error("last expected %0b got %0b", want.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [31:0] key, [63:32] new_value
    logic [2:0]  s_tuser = '0;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] entry_value
    logic [1:0]  m_tuser;        // [1:0] status
    logic        m_tlast;

    list_tracker tracker = new();
    int items_sent = 0;
    int gap_pct = 30;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    ordered_list_insert_delete #(
        .CAPACITY(LIST_CAPACITY)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Offer one command beat, with an optional idle burst ahead of it
    task automatic send_item(logic [2:0] act, logic signed [31:0] key,
                             logic signed [31:0] nv);
        if (!quiet && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {nv, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_command(act, key, nv);
        items_sent++;
    endtask

    // Mostly small values so duplicates occur, some extremes, some full range
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $signed($urandom_range(8)) - 4;
        if (r < 55)
            return 32'sh8000_0000;
        if (r < 60)
            return 32'sh7fff_ffff;
        return $urandom();
    endfunction

    // Prefer a key that is present so edits get past the search
    function automatic logic signed [31:0] pick_key();
        if (tracker.entries.size() != 0 && $urandom_range(99) < 80)
            return tracker.entries[$urandom_range(tracker.entries.size() - 1)];
        return pick_value();
    endfunction

    task automatic send_random(list_mode_t mode);
        int r;
        logic [2:0] act;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:
                act = (r < 45) ? ACT_APPEND : (r < 75) ? ACT_INSERT : (r < 85) ? ACT_DELETE :
                      (r < 95) ? ACT_DISPLAY : (r < 97) ? ACT_CLEAR : ACT_UNUSED_FIRST;
            MODE_SHRINK:
                act = (r < 12) ? ACT_APPEND : (r < 24) ? ACT_INSERT : (r < 70) ? ACT_DELETE :
                      (r < 90) ? ACT_DISPLAY : (r < 94) ? ACT_CLEAR : ACT_UNUSED_FIRST;
            default:
                act = (r < 30) ? ACT_APPEND : (r < 52) ? ACT_INSERT : (r < 74) ? ACT_DELETE :
                      (r < 92) ? ACT_DISPLAY : (r < 96) ? ACT_CLEAR : ACT_UNUSED_FIRST;
        endcase
        if (act == ACT_UNUSED_FIRST)
            act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
        send_item(act, pick_key(), pick_value());
    endtask

    // Accept and check result beats; drive ready in random bursts
    initial begin
        int run_left;
        bit stalling;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.check_beat(m_tuser, m_tdata, m_tlast);
            if (hold_req) begin
                // hold off long enough for the input side to back up
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = ($urandom_range(99) < 35);
                    run_left = stalling ? $urandom_range(18, 1) : $urandom_range(40, 1);
                end
                run_left--;
                m_tready <= !stalling;
            end
        end
    end

    // Main sequence: reset, directed commands, fill to capacity, random phases
    initial begin
        logic signed [31:0] absent;
        list_mode_t mode;
        int phase_len;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list cases
        send_item(ACT_DISPLAY, 0, 0);
        send_item(ACT_INSERT, 0, 1);
        send_item(ACT_DELETE, 0, 0);
        // extremes, then inserts at head and tail, and a missing key
        send_item(ACT_APPEND, 0, 32'sh8000_0000);
        send_item(ACT_APPEND, 0, 32'sh7fff_ffff);
        send_item(ACT_APPEND, 0, 0);
        send_item(ACT_APPEND, 0, -1);
        send_item(ACT_INSERT, 32'sh8000_0000, 7);
        send_item(ACT_INSERT, -1, 32'shaaaa_aaaa);
        send_item(ACT_INSERT, 12345, 32'sh5555_5555);
        // duplicates: delete must take the first match
        send_item(ACT_APPEND, 32'sh5555_5555, 0);
        send_item(ACT_DELETE, 0, 32'shffff_ffff);
        send_item(ACT_DELETE, 12345, 0);
        send_item(ACT_DISPLAY, 32'shffff_ffff, 32'shffff_ffff);
        send_item(ACT_DELETE, 7, 0);
        send_item(ACT_DELETE, 0, 0);
        send_item(ACT_UNUSED_FIRST, $urandom(), $urandom());
        send_item(ACT_UNUSED_FIRST + 3'd1, $urandom(), $urandom());
        send_item(ACT_UNUSED_LAST, $urandom(), $urandom());
        send_item(ACT_DISPLAY, 0, 0);
        send_item(ACT_CLEAR, $urandom(), $urandom());
        send_item(ACT_DISPLAY, 0, 0);

        // fill to capacity, then refusals and a full display
        while (tracker.entries.size() < LIST_CAPACITY)
            send_item(ACT_APPEND, pick_key(), pick_value());
        send_item(ACT_APPEND, 0, pick_value());
        send_item(ACT_INSERT, tracker.entries[LIST_CAPACITY - 1], pick_value());
        absent = $urandom();
        while (tracker.find_first(absent) >= 0)
            absent = $urandom();
        send_item(ACT_INSERT, absent, pick_value());
        send_item(ACT_DISPLAY, 0, 0);
        send_item(ACT_DELETE, tracker.entries[0], 0);

        // random phases that walk the list between empty and full
        while (items_sent < RANDOM_ITEMS) begin
            mode = list_mode_t'($urandom_range(2));
            gap_pct = ($urandom_range(3) == 0) ? 0 : 30;
            phase_len = $urandom_range(40, 15);
            for (int i = 0; i < phase_len && items_sent < RANDOM_ITEMS; i++) begin
                if (items_sent == HOLD_AT_ITEM)
                    hold_req = 1'b1;
                if (items_sent == PAUSE_AT_ITEM) begin
                    s_tvalid <= 1'b0;
                    while (tracker.awaited.size() != 0) @(posedge aclk);
                end
                if (items_sent >= RANDOM_ITEMS - QUIET_TAIL)
                    quiet = 1'b1;
                send_random(mode);
            end
        end
        s_tvalid <= 1'b0;

        // drain owed beats, then watch for strays
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.awaited.size() != 0) begin
            $error("%0d result beats never arrived", tracker.awaited.size());
            tracker.errors++;
        end

        $display("covered %0d commands, %0d result beats, %0d displays",
                 items_sent, tracker.beats_seen, tracker.displays);
        $display("list depth reached %0d of %0d, %0d full refusals",
                 tracker.deepest, LIST_CAPACITY, tracker.refusals);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> ordered_list_insert_delete.f
sv/oli_pkg.sv
sv/oli_cell.sv
sv/ordered_list_insert_delete.sv
test/ordered_list_insert_delete_test.sv
